### src/ceu_pkg.sv
// shared types and status codes of the c string escape decoder
package ceu_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_UTF8  = 3'd1;
	localparam logic [2:0] ST_BAD_CP    = 3'd2;
	localparam logic [2:0] ST_BAD_ESC   = 3'd3;
	localparam logic [2:0] ST_TRUNC_ESC = 3'd4;

	localparam int unsigned MAX_RES = 4;

	// everything one input byte produces, handed from the core to the output buffer
	typedef struct packed {
		logic [2:0]                 cnt;
		logic [MAX_RES-1:0][7:0]    bytes;
		logic                       byte_valid;
		logic                       last;
		logic [2:0]                 status;
	} ceu_res_t;

endpackage

### src/ceu_in_if.sv
// input channel: one raw byte of the escaped string per word
interface ceu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

### src/ceu_out_if.sv
// output channel: one decoded byte or end marker per word
interface ceu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       string_done;
	logic [2:0] status;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output string_done, output status, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input run_last,
		input string_done, input status, output ready);
endinterface

### src/ceu_core.sv
// utf-8 decode, escape handling and re-encode for one byte, with the decoder state
module ceu_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        in_byte,
	input  logic              is_last,
	output ceu_pkg::ceu_res_t res
);
	import ceu_pkg::*;

	typedef enum logic [1:0] {PH_PLAIN, PH_ESC, PH_HEX} phase_t;

	localparam logic [20:0] CH_BSLASH = 21'h5C;
	localparam logic [20:0] CH_X      = 21'h78;
	localparam logic [20:0] CH_U_LO   = 21'h75;
	localparam logic [20:0] CH_U_UP   = 21'h55;

	logic [20:0] code_accum_q, code_accum_d;
	logic [1:0]  cont_left_q, cont_left_d;
	logic [2:0]  seq_len_q, seq_len_d;
	phase_t      phase_q, phase_d;
	logic [31:0] hex_accum_q, hex_accum_d;
	logic [3:0]  hex_left_q, hex_left_d;
	logic [2:0]  err_q, err_d;

	logic        have;
	logic [20:0] cp;
	logic [20:0] acc_c;
	logic [34:0] enc;
	logic [8:0]  simple;
	logic [4:0]  hexd;
	logic [31:0] hex_c;
	logic [3:0]  left_c;

	function automatic logic bad_value(input logic [31:0] v);
		return (v >= 32'hD800 && v <= 32'hDFFF) || v > 32'h10FFFF;
	endfunction

	// {count, byte3, byte2, byte1, byte0}, byte0 goes out first
	function automatic logic [34:0] encode(input logic [20:0] c);
		if (c < 21'h80)
			return {3'd1, 24'd0, 1'b0, c[6:0]};
		else if (c < 21'h800)
			return {3'd2, 16'd0, 2'b10, c[5:0], 3'b110, c[10:6]};
		else if (c < 21'h10000)
			return {3'd3, 8'd0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
		else
			return {3'd4, 2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
	endfunction

	// {ok, value}
	function automatic logic [8:0] simple_escape(input logic [20:0] c);
		if (c[20:8] != 13'd0)
			return 9'd0;
		case (c[7:0])
			8'h61: return {1'b1, 8'h07};
			8'h62: return {1'b1, 8'h08};
			8'h65: return {1'b1, 8'h1B};
			8'h66: return {1'b1, 8'h0C};
			8'h6E: return {1'b1, 8'h0A};
			8'h72: return {1'b1, 8'h0D};
			8'h74: return {1'b1, 8'h09};
			8'h76: return {1'b1, 8'h0B};
			8'h5C, 8'h27, 8'h22, 8'h3F: return {1'b1, c[7:0]};
			default: return 9'd0;
		endcase
	endfunction

	// {ok, digit}
	function automatic logic [4:0] hex_value(input logic [20:0] c);
		logic [7:0] lo;
		lo = c[7:0];
		if (c[20:8] != 13'd0)
			return 5'd0;
		if (lo inside {[8'h30:8'h39]})
			return {1'b1, lo[3:0]};
		if ((lo inside {[8'h41:8'h46]}) || (lo inside {[8'h61:8'h66]}))
			return {1'b1, lo[3:0] + 4'd9};
		return 5'd0;
	endfunction

	always_comb begin
		code_accum_d = code_accum_q;
		cont_left_d  = cont_left_q;
		seq_len_d    = seq_len_q;
		phase_d      = phase_q;
		hex_accum_d  = hex_accum_q;
		hex_left_d   = hex_left_q;
		err_d        = err_q;
		have         = 1'b0;
		cp           = '0;
		acc_c        = '0;
		enc          = '0;
		simple       = '0;
		hexd         = '0;
		hex_c        = '0;
		left_c       = '0;

		if (err_q == ST_OK) begin
			// utf-8 decode
			if (cont_left_q == 2'd0) begin
				if (!in_byte[7]) begin
					cp   = {13'd0, in_byte};
					have = 1'b1;
				end else if (in_byte inside {[8'hC2:8'hDF]}) begin
					code_accum_d = {16'd0, in_byte[4:0]};
					cont_left_d  = 2'd1;
					seq_len_d    = 3'd2;
				end else if (in_byte inside {[8'hE0:8'hEF]}) begin
					code_accum_d = {17'd0, in_byte[3:0]};
					cont_left_d  = 2'd2;
					seq_len_d    = 3'd3;
				end else if (in_byte inside {[8'hF0:8'hF4]}) begin
					code_accum_d = {18'd0, in_byte[2:0]};
					cont_left_d  = 2'd3;
					seq_len_d    = 3'd4;
				end else begin
					err_d = ST_BAD_UTF8;
				end
			end else if (in_byte[7:6] != 2'b10) begin
				err_d = ST_BAD_UTF8;
			end else begin
				acc_c        = {code_accum_q[14:0], in_byte[5:0]};
				code_accum_d = acc_c;
				cont_left_d  = cont_left_q - 2'd1;
				if (cont_left_q == 2'd1) begin
					cp = acc_c;
					if ((seq_len_q == 3'd3 && acc_c < 21'h800) ||
							(seq_len_q == 3'd4 && acc_c < 21'h10000))
						err_d = ST_BAD_UTF8;
					else if (bad_value({11'd0, acc_c}))
						err_d = ST_BAD_CP;
					else
						have = 1'b1;
				end
			end

			// escape handling on a complete code point
			if (have) begin
				case (phase_q)
					PH_PLAIN: begin
						if (cp == CH_BSLASH)
							phase_d = PH_ESC;
						else
							enc = encode(cp);
					end
					PH_ESC: begin
						if (cp == CH_X || cp == CH_U_LO || cp == CH_U_UP) begin
							phase_d     = PH_HEX;
							hex_accum_d = '0;
							hex_left_d  = (cp == CH_X) ? 4'd2 : ((cp == CH_U_LO) ? 4'd4 : 4'd8);
						end else begin
							simple = simple_escape(cp);
							if (!simple[8]) begin
								err_d = ST_BAD_ESC;
							end else begin
								phase_d = PH_PLAIN;
								enc     = encode({13'd0, simple[7:0]});
							end
						end
					end
					PH_HEX: begin
						hexd = hex_value(cp);
						if (!hexd[4]) begin
							err_d = ST_BAD_ESC;
						end else begin
							hex_c       = {hex_accum_q[27:0], hexd[3:0]};
							hex_accum_d = hex_c;
							left_c      = (hex_left_q != 4'd0) ? hex_left_q - 4'd1 : hex_left_q;
							hex_left_d  = left_c;
							if (left_c == 4'd0) begin
								phase_d = PH_PLAIN;
								if (bad_value(hex_c))
									err_d = ST_BAD_CP;
								else
									enc = encode(hex_c[20:0]);
							end
						end
					end
					default: ;
				endcase
			end

			// string cut off inside a sequence or an escape
			if (err_d == ST_OK && is_last) begin
				if (cont_left_d != 2'd0)
					err_d = ST_BAD_UTF8;
				else if (phase_d != PH_PLAIN)
					err_d = ST_TRUNC_ESC;
			end
		end

		res.cnt        = (err_d != ST_OK) ? 3'd0 : enc[34:32];
		res.bytes      = enc[31:0];
		res.byte_valid = 1'b1;
		res.last       = is_last;
		res.status     = ST_OK;
		if (is_last && res.cnt == 3'd0) begin
			res.cnt        = 3'd1;
			res.bytes      = '0;
			res.byte_valid = 1'b0;
			res.status     = err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_accum_q <= '0;
			cont_left_q  <= '0;
			seq_len_q    <= '0;
			phase_q      <= PH_PLAIN;
			hex_accum_q  <= '0;
			hex_left_q   <= '0;
			err_q        <= ST_OK;
		end else if (step) begin
			if (is_last) begin
				code_accum_q <= '0;
				cont_left_q  <= '0;
				seq_len_q    <= '0;
				phase_q      <= PH_PLAIN;
				hex_accum_q  <= '0;
				hex_left_q   <= '0;
				err_q        <= ST_OK;
			end else begin
				code_accum_q <= code_accum_d;
				cont_left_q  <= cont_left_d;
				seq_len_q    <= seq_len_d;
				phase_q      <= phase_d;
				hex_accum_q  <= hex_accum_d;
				hex_left_q   <= hex_left_d;
				err_q        <= err_d;
			end
		end
	end

endmodule

### src/ceu_obuf.sv
// result register: holds up to four output words and shifts them out one per cycle while dec.ready is high
module ceu_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ceu_pkg::ceu_res_t res,
	output logic              can_load,
	ceu_out_if.source         dec
);
	import ceu_pkg::*;

	logic [2:0]              rem_q;
	logic [MAX_RES-1:0][7:0] bytes_q;
	logic                    bv_q;
	logic                    last_q;
	logic [2:0]              st_q;
	logic                    pop;

	assign pop      = dec.valid && dec.ready;
	assign can_load = (rem_q == 3'd0) || (rem_q == 3'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= res.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			bv_q    <= res.byte_valid;
			last_q  <= res.last;
			st_q    <= res.status;
		end else if (pop) begin
			bytes_q <= {8'd0, bytes_q[MAX_RES-1:1]};
		end
	end

	assign dec.valid       = (rem_q != 3'd0);
	assign dec.out_byte    = bytes_q[0];
	assign dec.byte_valid  = bv_q;
	assign dec.run_last    = (rem_q == 3'd1);
	assign dec.string_done = (rem_q == 3'd1) && last_q;
	assign dec.status      = ((rem_q == 3'd1) && last_q) ? st_q : ST_OK;

endmodule

### src/c_escape_unescaper_utf8_top.sv
// top level of the c string escape decoder over utf-8
//
// Takes an escaped UTF-8 string one byte per word on raw, is_last marking the
// final byte, and gives the unescaped UTF-8 bytes one per word on dec. Each
// input byte yields zero to four output words; the last byte of a string always
// yields at least one, carrying string_done and the string's status (0 ok,
// 1 bad utf-8, 2 invalid code point, 3 bad escape, 4 truncated escape). After a
// fault nothing more is emitted until the end of the string. An input word is
// registered in stage 1, decoded combinationally and loaded into a four-byte
// result register once that register can take it; its first output word then
// shows on dec and leaves when dec.ready is high. The block takes one byte per
// cycle for as long as each byte produces at most one output word and dec.ready
// stays high; a byte that produces several words holds the result register
// until the last of them has left, and that output port is what bounds the
// sustained rate. Bytes that produce nothing leave the result register free.
module c_escape_unescaper_utf8_top (
	input logic       clk,
	input logic       arst_n,
	ceu_in_if.sink    raw,
	ceu_out_if.source dec
);
	import ceu_pkg::*;

	// stage 1: input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       can_load;
	logic       step;
	ceu_res_t   res;

	// the byte in stage 1 is decoded when the result register is free or is
	// handing over its last word this cycle
	assign step      = valid_s1 && can_load;
	assign raw.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.valid && raw.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of stage 1, no reset needed
	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1 <= raw.in_byte;
			last_s1 <= raw.is_last;
		end
	end

	// decoder state and single-pass decode of one byte
	ceu_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.is_last (last_s1),
		.res     (res)
	);

	// result register feeding the output channel
	ceu_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.can_load (can_load),
		.dec      (dec)
	);

endmodule

### src/ceu_checker.sv
// port-level checks of the escape decoder and their binding to the top level
module ceu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       dec_valid,
	input logic       dec_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       run_last,
	input logic       string_done,
	input logic [2:0] status
);
	import ceu_pkg::*;

	// a stalled word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_ready |=> dec_valid && $stable(out_byte) && $stable(byte_valid)
			&& $stable(string_done) && $stable(status))
		else $error("output word changed while stalled");

	// an error status only shows on the closing word of a string
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && status != ST_OK |-> string_done && !byte_valid)
		else $error("status seen away from a quiet string end");

	// a word without data is always the end of a string and carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !byte_valid |-> run_last && string_done && out_byte == 8'd0)
		else $error("empty word that is not a string end");

	// the end of a string is also the end of its byte's run
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && string_done |-> run_last)
		else $error("string end without run end");

endmodule

bind c_escape_unescaper_utf8_top ceu_checker u_ceu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.dec_valid   (dec.valid),
	.dec_ready   (dec.ready),
	.out_byte    (dec.out_byte),
	.byte_valid  (dec.byte_valid),
	.run_last    (dec.run_last),
	.string_done (dec.string_done),
	.status      (dec.status)
);

### tb/ceu_checker.sv
// character codes shared by the stimulus, and the checker that predicts and compares decoder output
`timescale 1ns / 1ps

package ceu_tb_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_HEX2   = 8'h78;	// x
	localparam logic [7:0] CH_HEX4   = 8'h75;	// u
	localparam logic [7:0] CH_HEX8   = 8'h55;	// U
	localparam logic [7:0] CH_BEL    = 8'h61;	// a
	localparam logic [7:0] CH_BSP    = 8'h62;	// b
	localparam logic [7:0] CH_ESC    = 8'h65;	// e
	localparam logic [7:0] CH_FFEED  = 8'h66;	// f
	localparam logic [7:0] CH_LF     = 8'h6E;	// n
	localparam logic [7:0] CH_CR     = 8'h72;	// r
	localparam logic [7:0] CH_TAB    = 8'h74;	// t
	localparam logic [7:0] CH_VTAB   = 8'h76;	// v

	localparam logic [11:0][7:0] SIMPLE_ESCAPES = {CH_BEL, CH_BSP, CH_ESC, CH_FFEED, CH_LF,
		CH_CR, CH_TAB, CH_VTAB, CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK};

	typedef enum logic [2:0] {PH_TEXT, PH_BSLASH, PH_HEX} esc_phase_t;

endpackage

module ceu_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	ceu_in_if           raw,
	ceu_out_if          dec,
	output int unsigned fail_cnt,
	output int unsigned words_owed
);
	import ceu_pkg::*;
	import ceu_tb_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       data_ok;
		logic       run_last;
		logic       str_done;
		logic [2:0] status;
	} dec_word_t;

	dec_word_t   owed_q[$];
	dec_word_t   got_word;
	dec_word_t   want_word;
	int unsigned n_fail;

	// decoder state as the block should hold it
	logic [20:0] code_acc;
	logic [1:0]  cont_left;
	logic [2:0]  seq_len;
	esc_phase_t  phase;
	logic [31:0] hex_acc;
	logic [3:0]  hex_left;
	logic [2:0]  err;

	function automatic logic out_of_range(input logic [31:0] v);
		return (v >= 32'hD800 && v <= 32'hDFFF) || v > 32'h10FFFF;
	endfunction

	// appends one byte at the tail of a byte queue
	function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] b);
		q.insert(q.size(), b);
	endfunction

	function automatic void encode(ref logic [7:0] q[$], input logic [31:0] v);
		if (v < 32'h80) begin
			add_byte(q, v[7:0]);
		end else if (v < 32'h800) begin
			add_byte(q, {3'b110, v[10:6]});
			add_byte(q, {2'b10, v[5:0]});
		end else if (v < 32'h10000) begin
			add_byte(q, {4'b1110, v[15:12]});
			add_byte(q, {2'b10, v[11:6]});
			add_byte(q, {2'b10, v[5:0]});
		end else begin
			add_byte(q, {5'b11110, v[20:18]});
			add_byte(q, {2'b10, v[17:12]});
			add_byte(q, {2'b10, v[11:6]});
			add_byte(q, {2'b10, v[5:0]});
		end
	endfunction

	// top bit set when the character is a hex digit
	function automatic logic [4:0] hex_nibble(input logic [20:0] c);
		if (c >= 21'h30 && c <= 21'h39)
			return {1'b1, c[3:0]};
		if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66))
			return {1'b1, c[3:0] + 4'd9};
		return 5'd0;
	endfunction

	// top bit set when the character names a one-letter escape
	function automatic logic [8:0] simple_escape(input logic [20:0] c);
		if (c > 21'h7F)
			return 9'd0;
		case (c[7:0])
			CH_BEL:   return {1'b1, 8'h07};
			CH_BSP:   return {1'b1, 8'h08};
			CH_ESC:   return {1'b1, 8'h1B};
			CH_FFEED: return {1'b1, 8'h0C};
			CH_LF:    return {1'b1, 8'h0A};
			CH_CR:    return {1'b1, 8'h0D};
			CH_TAB:   return {1'b1, 8'h09};
			CH_VTAB:  return {1'b1, 8'h0B};
			CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK: return {1'b1, c[7:0]};
			default:  return 9'd0;
		endcase
	endfunction

	task automatic clear_state();
		code_acc  = '0;
		cont_left = '0;
		seq_len   = '0;
		phase     = PH_TEXT;
		hex_acc   = '0;
		hex_left  = '0;
		err       = ST_OK;
	endtask

	// one decoded code point through the escape logic
	task automatic take_point(input logic [20:0] c, ref logic [7:0] q[$]);
		logic [8:0] esc;
		logic [4:0] nib;
		case (phase)
			PH_TEXT: begin
				if (c == {13'd0, CH_BSLASH})
					phase = PH_BSLASH;
				else
					encode(q, {11'd0, c});
			end
			PH_BSLASH: begin
				esc = simple_escape(c);
				if (c == {13'd0, CH_HEX2} || c == {13'd0, CH_HEX4} || c == {13'd0, CH_HEX8}) begin
					phase    = PH_HEX;
					hex_acc  = '0;
					hex_left = (c == {13'd0, CH_HEX2}) ? 4'd2 : (c == {13'd0, CH_HEX4}) ? 4'd4 : 4'd8;
				end else if (!esc[8]) begin
					err = ST_BAD_ESC;
				end else begin
					phase = PH_TEXT;
					encode(q, {24'd0, esc[7:0]});
				end
			end
			default: begin
				nib = hex_nibble(c);
				if (!nib[4]) begin
					err = ST_BAD_ESC;
				end else begin
					hex_acc = {hex_acc[27:0], nib[3:0]};
					if (hex_left != 0)
						hex_left = hex_left - 4'd1;
					if (hex_left == 0) begin
						phase = PH_TEXT;
						if (out_of_range(hex_acc))
							err = ST_BAD_CP;
						else
							encode(q, hex_acc);
					end
				end
			end
		endcase
	endtask

	task automatic predict(input logic [7:0] b, input logic last);
		logic [7:0]  q[$];
		logic [20:0] c;
		logic        have;
		dec_word_t   w;
		have = 1'b0;
		c    = '0;
		if (err == ST_OK) begin
			if (cont_left == 0) begin
				if (b < 8'h80) begin
					c    = {13'd0, b};
					have = 1'b1;
				end else if (b >= 8'hC2 && b <= 8'hDF) begin
					code_acc  = {16'd0, b[4:0]};
					cont_left = 2'd1;
					seq_len   = 3'd2;
				end else if (b >= 8'hE0 && b <= 8'hEF) begin
					code_acc  = {17'd0, b[3:0]};
					cont_left = 2'd2;
					seq_len   = 3'd3;
				end else if (b >= 8'hF0 && b <= 8'hF4) begin
					code_acc  = {18'd0, b[2:0]};
					cont_left = 2'd3;
					seq_len   = 3'd4;
				end else begin
					err = ST_BAD_UTF8;
				end
			end else if (b[7:6] != 2'b10) begin
				err = ST_BAD_UTF8;
			end else begin
				code_acc  = {code_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 0) begin
					// overlong forms, then surrogates and values past the last plane
					if ((seq_len == 3'd3 && code_acc < 21'h800) ||
						(seq_len == 3'd4 && code_acc < 21'h10000))
						err = ST_BAD_UTF8;
					else if (out_of_range({11'd0, code_acc}))
						err = ST_BAD_CP;
					else begin
						c    = code_acc;
						have = 1'b1;
					end
				end
			end
			if (have)
				take_point(c, q);
			if (err == ST_OK && last) begin
				if (cont_left != 0)
					err = ST_BAD_UTF8;
				else if (phase != PH_TEXT)
					err = ST_TRUNC_ESC;
			end
		end
		if (err != ST_OK)
			q.delete();
		foreach (q[k]) begin
			w = '{q[k], 1'b1, k == q.size() - 1, (k == q.size() - 1) && last, ST_OK};
			owed_q.insert(owed_q.size(), w);
		end
		if (last && q.size() == 0) begin
			w = '{8'h00, 1'b0, 1'b1, 1'b1, err};
			owed_q.insert(owed_q.size(), w);
		end
		if (last)
			clear_state();
	endtask

	// output side first, so a word never matches what the same edge predicts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			owed_q.delete();
			n_fail = 0;
			fail_cnt   <= 0;
			words_owed <= 0;
		end else begin
			if (dec.valid && dec.ready) begin
				got_word = '{dec.out_byte, dec.byte_valid, dec.run_last, dec.string_done, dec.status};
				if (owed_q.size() == 0) begin
					if (n_fail < 10)
						$display("unexpected word at %0t: byte %h valid %b run_last %b done %b status %0d",
							$realtime, got_word.data, got_word.data_ok, got_word.run_last,
							got_word.str_done, got_word.status);
					n_fail++;
				end else begin
					want_word = owed_q.pop_front();
					if (got_word !== want_word) begin
						if (n_fail < 10)
							$display({"mismatch at %0t: expected byte %h valid %b run_last %b done %b ",
								"status %0d, got byte %h valid %b run_last %b done %b status %0d"},
								$realtime, want_word.data, want_word.data_ok, want_word.run_last,
								want_word.str_done, want_word.status, got_word.data,
								got_word.data_ok, got_word.run_last, got_word.str_done,
								got_word.status);
						n_fail++;
					end
				end
			end
			if (raw.valid && raw.ready)
				predict(raw.in_byte, raw.is_last);
			fail_cnt   <= n_fail;
			words_owed <= owed_q.size();
		end
	end

endmodule

### tb/testbench.sv
// top of the decoder testbench: clock, reset, string stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module testbench;
	import ceu_tb_pkg::*;

	// a stall this long with nothing moving on either side means the block has hung
	localparam int unsigned QUIET_LIMIT  = 5000;
	// random part stops once about this many words have gone in
	localparam int unsigned RANDOM_WORDS = 235;
	// strings sent under one setting of idling before moving to the next
	localparam int unsigned PHASE_LEN    = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned quiet_cycles = 0;
	int unsigned words_sent;
	int unsigned words_owed;
	int unsigned fail_cnt;

	ceu_in_if  raw ();
	ceu_out_if dec ();

	c_escape_unescaper_utf8_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.dec    (dec)
	);

	ceu_scoreboard i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw        (raw),
		.dec        (dec),
		.fail_cnt   (fail_cnt),
		.words_owed (words_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: drops ready at random, as often as the current phase says
	always @(posedge clk)
		dec.ready <= ($urandom_range(0, 99) >= stall_pct);

	// watchdog: counts cycles in which neither channel moves a word
	always @(posedge clk) begin
		if ((raw.valid && raw.ready) || (dec.valid && dec.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// idling settings: none, sender idle, receiver stalling, both a little
	task automatic set_pressure(input int unsigned sel);
		case (sel % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 77; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 77; end
			default: begin idle_pct = 27; stall_pct = 27; end
		endcase
	endtask

	// appends one byte at the tail of a string
	function automatic void add_byte(ref logic [7:0] s[$], input logic [7:0] b);
		s.insert(s.size(), b);
	endfunction

	function automatic logic [7:0] rnd(input logic [7:0] lo, input logic [7:0] hi);
		return 8'($urandom_range({24'd0, hi}, {24'd0, lo}));
	endfunction

	// hex digit in either case, picked at random
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + {4'd0, v};
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
	endfunction

	function automatic void put_utf8(ref logic [7:0] s[$], input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_byte(s, cp[7:0]);
		end else if (cp < 21'h800) begin
			add_byte(s, {3'b110, cp[10:6]});
			add_byte(s, {2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			add_byte(s, {4'b1110, cp[15:12]});
			add_byte(s, {2'b10, cp[11:6]});
			add_byte(s, {2'b10, cp[5:0]});
		end else begin
			add_byte(s, {5'b11110, cp[20:18]});
			add_byte(s, {2'b10, cp[17:12]});
			add_byte(s, {2'b10, cp[11:6]});
			add_byte(s, {2'b10, cp[5:0]});
		end
	endfunction

	// backslash, the escape letter, then the digits most significant first
	function automatic void put_hex(ref logic [7:0] s[$], input logic [7:0] kind,
		input logic [31:0] val, input int digits);
		add_byte(s, CH_BSLASH);
		add_byte(s, kind);
		for (int i = digits - 1; i >= 0; i--)
			add_byte(s, hex_char(val[i*4 +: 4]));
	endfunction

	// a well-formed piece of text: plain characters of every length and every escape
	function automatic void add_clean(ref logic [7:0] s[$]);
		logic [20:0] cp;
		logic [7:0]  ch;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				ch = rnd(8'h00, 8'h7F);
				add_byte(s, ch == CH_BSLASH ? CH_QMARK : ch);
			end
			3: put_utf8(s, 21'($urandom_range('h80, 'h7FF)));
			4: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				if (cp >= 21'hD800 && cp <= 21'hDFFF)
					cp -= 21'h800;
				put_utf8(s, cp);
			end
			5: put_utf8(s, 21'($urandom_range('h10000, 'h10FFFF)));
			6: begin
				add_byte(s, CH_BSLASH);
				add_byte(s, SIMPLE_ESCAPES[$urandom_range(0, 11)]);
			end
			7: put_hex(s, CH_HEX2, 32'($urandom_range(0, 'hFF)), 2);
			8: begin
				cp = 21'($urandom_range(0, 'hFFFF));
				if (cp >= 21'hD800 && cp <= 21'hDFFF)
					cp -= 21'h800;
				put_hex(s, CH_HEX4, {11'd0, cp}, 4);
			end
			default: put_hex(s, CH_HEX8, 32'($urandom_range(0, 'h10FFFF)), 8);
		endcase
	endfunction

	// noise and broken pieces: stray bytes, bad escapes, overlong and out-of-range values
	function automatic void add_fault(ref logic [7:0] s[$]);
		int unsigned pos;
		pos = $urandom_range(0, 3);
		case ($urandom_range(0, 8))
			0: add_byte(s, rnd(8'h00, 8'hFF));
			1: begin
				add_byte(s, CH_BSLASH);
				add_byte(s, rnd(8'h00, 8'hFF));
			end
			2: begin
				add_byte(s, CH_BSLASH);
				add_byte(s, CH_HEX4);
				for (int i = 0; i < 4; i++)
					add_byte(s, i == pos ? rnd(8'h00, 8'hFF) : hex_char(4'($urandom_range(0, 15))));
			end
			3: add_byte(s, rnd(8'hC2, 8'hF4));
			4: begin
				case (pos)
					0: add_byte(s, rnd(8'hC0, 8'hC1));
					1: begin
						add_byte(s, 8'hE0);
						add_byte(s, rnd(8'h80, 8'h9F));
						add_byte(s, rnd(8'h80, 8'hBF));
					end
					default: begin
						add_byte(s, 8'hF0);
						add_byte(s, rnd(8'h80, 8'h8F));
						add_byte(s, rnd(8'h80, 8'hBF));
						add_byte(s, rnd(8'h80, 8'hBF));
					end
				endcase
			end
			5: put_hex(s, CH_HEX8, $urandom(), 8);
			6: put_hex(s, CH_HEX4, 32'($urandom_range('hD800, 'hDFFF)), 4);
			7: begin
				// encodes a value past the last plane
				add_byte(s, 8'hF4);
				add_byte(s, rnd(8'h90, 8'hBF));
				add_byte(s, rnd(8'h80, 8'hBF));
				add_byte(s, rnd(8'h80, 8'hBF));
			end
			default: begin
				add_byte(s, CH_BSLASH);
				add_byte(s, CH_HEX2);
				add_byte(s, hex_char(4'($urandom_range(0, 15))));
			end
		endcase
	endfunction

	// sender: entered just after a rising edge; ready is looked at mid-cycle, where it is
	// settled, and the word goes across at the edge that follows
	task automatic send_word(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			raw.valid <= 1'b0;
			@(posedge clk);
		end
		raw.valid   <= 1'b1;
		raw.in_byte <= b;
		raw.is_last <= last;
		do
			@(negedge clk);
		while (!raw.ready);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic send_string(input logic [7:0] s[$]);
		foreach (s[i])
			send_word(s[i], i == s.size() - 1);
	endtask

	initial begin
		logic [7:0]  text[$];
		int unsigned str_no;
		int unsigned n_tok;
		int unsigned bad_at;

		raw.valid   <= 1'b0;
		raw.in_byte <= 8'h00;
		raw.is_last <= 1'b0;
		arst_n = 1'b0;
		set_pressure(0);
		words_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		// smallest two-byte character, then the highest code point: four words from one byte
		text = {8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_string(text);
		// hex escape in mixed case, re-encoded as two bytes
		text = {CH_BSLASH, CH_HEX2, 8'h46, 8'h66};
		send_string(text);
		// simple escape landing on the final byte
		text = {CH_BSLASH, CH_TAB};
		send_string(text);
		// surrogate spelt out in utf-8
		text = {8'hED, 8'hA0, 8'h80};
		send_string(text);
		// bad lead byte, then a byte that must be swallowed
		text = {8'hFF, 8'h41};
		send_string(text);
		// unknown escape letter
		text = {CH_BSLASH, 8'h71};
		send_string(text);
		// string ending right after a backslash
		text = {CH_BSLASH};
		send_string(text);
		// overlong three-byte form
		text = {8'hE0, 8'h80, 8'h80};
		send_string(text);
		// string ending inside a sequence
		text = {8'hE2};
		send_string(text);
		// non-hex character inside a hex escape
		text = {CH_BSLASH, CH_HEX2, 8'h67};
		send_string(text);

		// random strings: mostly clean, one in four carries one broken piece
		words_sent = 0;
		str_no     = 0;
		while (words_sent < RANDOM_WORDS) begin
			if (str_no % PHASE_LEN == 0)
				set_pressure(str_no / PHASE_LEN);
			text.delete();
			n_tok  = $urandom_range(1, 8);
			bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_tok - 1) : n_tok;
			for (int t = 0; t < n_tok; t++) begin
				if (t == bad_at)
					add_fault(text);
				else
					add_clean(text);
			end
			send_string(text);
			str_no++;
		end
		raw.valid <= 1'b0;

		// drain: wait until the checker owes nothing, then a few cycles for strays
		do
			@(posedge clk);
		while (words_owed != 0);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
